>>> rtl/core/lps_pkg.sv
// lps_pkg: shared types for the line pixel stepper.
// Command codes and the per-axis step direction encoding.
// No dependencies.
package lps_pkg;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_NEXT  = 1'b1
   } cmd_type;

   // two's complement view of -1, 0, +1
   typedef enum logic [1:0] {
      STEP_ZERO = 2'b00,
      STEP_POS  = 2'b01,
      STEP_NEG  = 2'b11
   } step_type;

   localparam int unsigned COLOR_BITS = 32;

endpackage

>>> rtl/core/lps_axis_setup.sv
// lps_axis_setup: absolute delta and step direction of one axis.
// Depends on lps_pkg.
module lps_axis_setup
   import lps_pkg::*;
#(
   parameter int unsigned COORD_BITS = 11
) (
   input  logic [COORD_BITS-1:0] coord_a,
   input  logic [COORD_BITS-1:0] coord_b,
   output logic [COORD_BITS-1:0] mag,
   output step_type              dir
);

   always_comb begin
      if (coord_b > coord_a) begin
         mag = coord_b - coord_a;
         dir = STEP_POS;
      end else if (coord_b == coord_a) begin
         mag = '0;
         dir = STEP_ZERO;
      end else begin
         mag = coord_a - coord_b;
         dir = STEP_NEG;
      end
   end

endmodule

>>> rtl/core/lps_axis_advance.sv
// lps_axis_advance: one error-accumulator step of one axis.
// Depends on lps_pkg.
module lps_axis_advance
   import lps_pkg::*;
#(
   parameter int unsigned COORD_BITS = 11
) (
   input  logic [COORD_BITS:0]   err,
   input  logic [COORD_BITS-1:0] mag,
   input  logic [COORD_BITS-1:0] major,
   input  step_type              dir,
   input  logic [COORD_BITS-1:0] pos,
   output logic [COORD_BITS:0]   err_next,
   output logic [COORD_BITS-1:0] pos_next
);

   logic [COORD_BITS:0] sum;
   logic                over;

   assign sum  = err + {1'b0, mag};
   assign over = sum > {1'b0, major};

   always_comb begin
      err_next = sum;
      pos_next = pos;
      if (over) begin
         err_next = sum - {1'b0, major};
         case (dir)
            STEP_POS: pos_next = pos + {{(COORD_BITS-1){1'b0}}, 1'b1};
            STEP_NEG: pos_next = pos - {{(COORD_BITS-1){1'b0}}, 1'b1};
            default:  pos_next = pos;
         endcase
      end
   end

endmodule

>>> rtl/core/line_pixel_stepper_top.sv
// line_pixel_stepper_top: line rasterizer, at most one pixel per beat.
// Depends on lps_pkg, lps_axis_setup, lps_axis_advance.
//
// Usage:
//   req_* channel (valid/ready): req_command CMD_START loads two endpoints
//   and yields the first pixel; CMD_NEXT yields the next pixel of the line.
//   A line of major length N gives N+1 pixels; the last carries rsp_is_last.
//   A next beat with no active line gives a response with rsp_pixel_valid=0.
//   rsp_* channel (valid/ready): one response beat per request beat.
//   csr_wr_en/csr_wr_data: draw color, write only while the block is idle.
// Response: registered, valid in the cycle after the request beat.
// Throughput: one request beat per cycle unless a held response stalls it; the
//   line state update (add, compare, subtract per axis) completes in the accept
//   cycle, so consecutive steps chain with no bubble.
// Stall: the single response register holds while rsp_ready is low;
//   req_ready = !rsp_valid || rsp_ready, so a taken response frees the
//   slot in the same cycle.
// Reset: synchronous, clears line state, color and the response slot.
module line_pixel_stepper_top
   import lps_pkg::*;
#(
   parameter int unsigned COORD_BITS = 11
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_command,
   input  logic [COORD_BITS-1:0] req_start_x,
   input  logic [COORD_BITS-1:0] req_start_y,
   input  logic [COORD_BITS-1:0] req_end_x,
   input  logic [COORD_BITS-1:0] req_end_y,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COORD_BITS-1:0] rsp_pixel_x,
   output logic [COORD_BITS-1:0] rsp_pixel_y,
   output logic [COLOR_BITS-1:0] rsp_pixel_color,
   output logic                  rsp_pixel_valid,
   output logic                  rsp_is_last,
   input  logic                  csr_wr_en,
   input  logic [COLOR_BITS-1:0] csr_wr_data
);

   logic [COLOR_BITS-1:0] color_ff, color_in;
   logic [COORD_BITS-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [COORD_BITS:0]   err_x_ff, err_x_in, err_y_ff, err_y_in;
   logic [COORD_BITS-1:0] abs_dx_ff, abs_dx_in, abs_dy_ff, abs_dy_in;
   logic [COORD_BITS-1:0] major_ff, major_in;
   step_type              step_x_ff, step_x_in, step_y_ff, step_y_in;
   logic [COORD_BITS-1:0] left_ff, left_in;

   logic                  out_valid_ff, out_valid_in;
   logic [COORD_BITS-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [COLOR_BITS-1:0] out_color_ff, out_color_in;
   logic                  out_pix_ff, out_pix_in, out_last_ff, out_last_in;

   logic                  accept;
   logic [COORD_BITS-1:0] new_dx, new_dy, new_major;
   step_type              new_sx, new_sy;
   logic [COORD_BITS:0]   adv_err_x, adv_err_y;
   logic [COORD_BITS-1:0] adv_x, adv_y;

   assign req_ready = !out_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   lps_axis_setup #(.COORD_BITS(COORD_BITS)) u_setup_x (
      .coord_a (req_start_x),
      .coord_b (req_end_x),
      .mag     (new_dx),
      .dir     (new_sx)
   );

   lps_axis_setup #(.COORD_BITS(COORD_BITS)) u_setup_y (
      .coord_a (req_start_y),
      .coord_b (req_end_y),
      .mag     (new_dy),
      .dir     (new_sy)
   );

   assign new_major = (new_dx > new_dy) ? new_dx : new_dy;

   lps_axis_advance #(.COORD_BITS(COORD_BITS)) u_adv_x (
      .err      (err_x_ff),
      .mag      (abs_dx_ff),
      .major    (major_ff),
      .dir      (step_x_ff),
      .pos      (cur_x_ff),
      .err_next (adv_err_x),
      .pos_next (adv_x)
   );

   lps_axis_advance #(.COORD_BITS(COORD_BITS)) u_adv_y (
      .err      (err_y_ff),
      .mag      (abs_dy_ff),
      .major    (major_ff),
      .dir      (step_y_ff),
      .pos      (cur_y_ff),
      .err_next (adv_err_y),
      .pos_next (adv_y)
   );

   always_comb begin
      color_in     = csr_wr_en ? csr_wr_data : color_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      err_x_in     = err_x_ff;
      err_y_in     = err_y_ff;
      abs_dx_in    = abs_dx_ff;
      abs_dy_in    = abs_dy_ff;
      major_in     = major_ff;
      step_x_in    = step_x_ff;
      step_y_in    = step_y_ff;
      left_in      = left_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_color_in = out_color_ff;
      out_pix_in   = out_pix_ff;
      out_last_in  = out_last_ff;
      if (accept) begin
         out_valid_in = 1'b1;
         out_x_in     = '0;
         out_y_in     = '0;
         out_color_in = '0;
         out_pix_in   = 1'b0;
         out_last_in  = 1'b0;
         if (cmd_type'(req_command) == CMD_START) begin
            cur_x_in     = req_start_x;
            cur_y_in     = req_start_y;
            abs_dx_in    = new_dx;
            abs_dy_in    = new_dy;
            step_x_in    = new_sx;
            step_y_in    = new_sy;
            major_in     = new_major;
            err_x_in     = {1'b0, new_dx};
            err_y_in     = {1'b0, new_dy};
            left_in      = new_major;
            out_x_in     = req_start_x;
            out_y_in     = req_start_y;
            out_color_in = color_ff;
            out_pix_in   = 1'b1;
            out_last_in  = (new_major == '0);
         end else if (left_ff != '0) begin
            cur_x_in     = adv_x;
            cur_y_in     = adv_y;
            err_x_in     = adv_err_x;
            err_y_in     = adv_err_y;
            left_in      = left_ff - {{(COORD_BITS-1){1'b0}}, 1'b1};
            out_x_in     = adv_x;
            out_y_in     = adv_y;
            out_color_in = color_ff;
            out_pix_in   = 1'b1;
            out_last_in  = (left_ff == {{(COORD_BITS-1){1'b0}}, 1'b1});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff     <= '0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         err_x_ff     <= '0;
         err_y_ff     <= '0;
         abs_dx_ff    <= '0;
         abs_dy_ff    <= '0;
         major_ff     <= '0;
         step_x_ff    <= STEP_ZERO;
         step_y_ff    <= STEP_ZERO;
         left_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         color_ff     <= color_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         err_x_ff     <= err_x_in;
         err_y_ff     <= err_y_in;
         abs_dx_ff    <= abs_dx_in;
         abs_dy_ff    <= abs_dy_in;
         major_ff     <= major_in;
         step_x_ff    <= step_x_in;
         step_y_ff    <= step_y_in;
         left_ff      <= left_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_color_ff <= out_color_in;
      out_pix_ff   <= out_pix_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_x     = out_x_ff;
   assign rsp_pixel_y     = out_y_ff;
   assign rsp_pixel_color = out_color_ff;
   assign rsp_pixel_valid = out_pix_ff;
   assign rsp_is_last     = out_last_ff;

`ifndef ASSERT_OFF
   a_err_x_bound: assert property (@(posedge clock) disable iff (reset)
      err_x_ff <= {1'b0, major_ff})
      else $error("x error accumulator above major length");

   a_err_y_bound: assert property (@(posedge clock) disable iff (reset)
      err_y_ff <= {1'b0, major_ff})
      else $error("y error accumulator above major length");

   a_major_is_delta: assert property (@(posedge clock) disable iff (reset)
      major_ff == abs_dx_ff || major_ff == abs_dy_ff)
      else $error("major length matches neither delta");

   a_last_is_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_last |-> rsp_pixel_valid)
      else $error("last flag on an empty beat");

   a_point_line: assert property (@(posedge clock) disable iff (reset)
      accept && req_command == CMD_START && req_start_x == req_end_x &&
      req_start_y == req_end_y |=> rsp_valid && rsp_is_last && left_ff == '0)
      else $error("single point line not closed on first pixel");
`endif

endmodule

>>> dv/tb_top.sv
// tb_top: self-checking bench for line_pixel_stepper_top, with directed and random lines.
// Predicts every pixel beat in-bench and scores the rsp channel under random stalls.
// Depends on lps_pkg and line_pixel_stepper_top.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lps_pkg::*;

   localparam int CW          = 11;
   localparam int COORD_MAX   = (1 << CW) - 1;
   localparam int TOTAL_BEATS = 1550;
   localparam int QUIET_FROM  = 1350;
   localparam int CYCLE_LIMIT = 500000;

   typedef struct packed {
      logic [CW-1:0]         x;
      logic [CW-1:0]         y;
      logic [COLOR_BITS-1:0] color;
      logic                  drawn;
      logic                  last;
   } pixel_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_command = CMD_START;
   logic [CW-1:0]         req_start_x = '0;
   logic [CW-1:0]         req_start_y = '0;
   logic [CW-1:0]         req_end_x = '0;
   logic [CW-1:0]         req_end_y = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [CW-1:0]         rsp_pixel_x;
   logic [CW-1:0]         rsp_pixel_y;
   logic [COLOR_BITS-1:0] rsp_pixel_color;
   logic                  rsp_pixel_valid;
   logic                  rsp_is_last;
   logic                  csr_wr_en = 1'b0;
   logic [COLOR_BITS-1:0] csr_wr_data = '0;

   // predicted line state
   logic [COLOR_BITS-1:0] draw_color_q = '0;
   logic [CW-1:0]         line_x = '0, line_y = '0;
   logic [CW:0]           acc_x = '0, acc_y = '0;
   logic [CW-1:0]         span_x = '0, span_y = '0;
   logic [CW-1:0]         major = '0;
   step_type              dir_x = STEP_ZERO, dir_y = STEP_ZERO;
   logic [CW-1:0]         line_left = '0;

   pixel_type pending_pixels[$];
   int     sent_beats = 0;
   int     mismatches = 0;
   int     cycle_count = 0;
   bit     idle_on = 1'b1;

   line_pixel_stepper_top #(.COORD_BITS(CW)) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_pixel_valid (rsp_pixel_valid),
      .rsp_is_last     (rsp_is_last),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------- line predictor ----------------

   task automatic setup_axis(input logic [CW-1:0] a, input logic [CW-1:0] b,
                             output logic [CW-1:0] mag, output step_type dir);
      if (b > a) begin
         mag = b - a;
         dir = STEP_POS;
      end else if (b == a) begin
         mag = '0;
         dir = STEP_ZERO;
      end else begin
         mag = a - b;
         dir = STEP_NEG;
      end
   endtask

   task automatic advance_axis(inout logic [CW:0] acc, input logic [CW-1:0] mag,
                               input step_type dir, inout logic [CW-1:0] pos);
      acc = acc + {1'b0, mag};
      if (acc > {1'b0, major}) begin
         acc = acc - {1'b0, major};
         case (dir)
            STEP_POS: pos = pos + CW'(1);
            STEP_NEG: pos = pos - CW'(1);
            default: ;
         endcase
      end
   endtask

   task automatic trace_line_beat(input cmd_type cmd, input logic [CW-1:0] sx,
                                  input logic [CW-1:0] sy, input logic [CW-1:0] ex,
                                  input logic [CW-1:0] ey);
      pixel_type px;
      px = '0;
      if (cmd == CMD_START) begin
         setup_axis(sx, ex, span_x, dir_x);
         setup_axis(sy, ey, span_y, dir_y);
         major     = (span_x > span_y) ? span_x : span_y;
         line_x    = sx;
         line_y    = sy;
         acc_x     = {1'b0, span_x};
         acc_y     = {1'b0, span_y};
         line_left = major;
         px.drawn  = 1'b1;
      end else if (line_left != '0) begin
         advance_axis(acc_x, span_x, dir_x, line_x);
         advance_axis(acc_y, span_y, dir_y, line_y);
         line_left = line_left - CW'(1);
         px.drawn  = 1'b1;
      end
      if (px.drawn) begin
         px.x     = line_x;
         px.y     = line_y;
         px.color = draw_color_q;
         px.last  = (line_left == '0);
      end
      pending_pixels.push_back(px);
   endtask

   // ---------------- drivers ----------------

   // entered and left on a rising edge; req_valid stays up between back-to-back beats
   task automatic send_beat(input cmd_type cmd, input logic [CW-1:0] sx,
                            input logic [CW-1:0] sy, input logic [CW-1:0] ex,
                            input logic [CW-1:0] ey);
      if (idle_on && $urandom_range(7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(14, 1)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_start_x <= sx;
      req_start_y <= sy;
      req_end_x   <= ex;
      req_end_y   <= ey;
      do @(posedge clock); while (!req_ready);
      trace_line_beat(cmd, sx, sy, ex, ey);
      sent_beats++;
   endtask

   task automatic step_line(input int n);
      repeat (n) send_beat(CMD_NEXT, CW'($urandom), CW'($urandom), CW'($urandom),
                           CW'($urandom));
   endtask

   task automatic run_line(input logic [CW-1:0] sx, input logic [CW-1:0] sy,
                           input logic [CW-1:0] ex, input logic [CW-1:0] ey, input int extra);
      send_beat(CMD_START, sx, sy, ex, ey);
      step_line(int'(line_left) + extra);
   endtask

   task automatic drain_pixels();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic set_draw_color(input logic [COLOR_BITS-1:0] color);
      drain_pixels();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= color;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      draw_color_q  = color;
   endtask

   function automatic logic [CW-1:0] near_coord(input int c, input int span);
      int lo, hi;
      lo = (c - span < 0) ? 0 : c - span;
      hi = (c + span > COORD_MAX) ? COORD_MAX : c + span;
      return CW'($urandom_range(hi, lo));
   endfunction

   // rsp side backpressure
   initial begin
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(9) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(14, 1)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (idle_on && $urandom_range(9) == 0) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(60, 20)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------- scoreboard ----------------

   always @(posedge clock) begin
      pixel_type want, got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_pixel_x, rsp_pixel_y, rsp_pixel_color, rsp_pixel_valid, rsp_is_last};
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected pixel beat x=%0d y=%0d color=%h valid=%b last=%b",
                        $realtime, got.x, got.y, got.color, got.drawn, got.last);
         end else begin
            want = pending_pixels.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: pixel mismatch", $realtime);
                  $display("   exp x=%0d y=%0d color=%h valid=%b last=%b",
                           want.x, want.y, want.color, want.drawn, want.last);
                  $display("   got x=%0d y=%0d color=%h valid=%b last=%b",
                           got.x, got.y, got.color, got.drawn, got.last);
               end
            end
         end
      end
   end

   // ---------------- tests ----------------

   task automatic test_idle_after_reset();
      step_line(1);
      send_beat(CMD_START, '0, '0, '0, '0);
      step_line(1);
      send_beat(CMD_START, '1, '1, '1, '1);
   endtask

   task automatic test_directed_lines();
      set_draw_color('1);
      run_line('1, '0, CW'(COORD_MAX - 3), CW'(2), 1);
      run_line('0, '1, CW'(2), CW'(COORD_MAX - 4), 0);
      // abandon a line mid-way with a fresh start
      send_beat(CMD_START, CW'(5), CW'(5), '0, CW'(9));
      step_line(2);
      run_line(CW'(10), CW'(10), CW'(13), CW'(10), 1);
   endtask

   task automatic test_color_settings();
      set_draw_color('0);
      run_line(CW'(100), CW'(200), CW'(96), CW'(205), 0);
      set_draw_color(32'hA5A5_5A5A);
      run_line(CW'(300), CW'(300), CW'(300), CW'(297), 1);
      set_draw_color($urandom);
   endtask

   task automatic test_random_lines();
      int kind, span, next_color_at;
      logic [CW-1:0] sx, sy;
      next_color_at = sent_beats + 350;
      while (sent_beats < TOTAL_BEATS) begin
         if (sent_beats >= QUIET_FROM) idle_on = 1'b0;
         if (sent_beats >= next_color_at) begin
            set_draw_color($urandom);
            next_color_at += 350;
         end
         kind = $urandom_range(99);
         sx   = CW'($urandom_range(COORD_MAX));
         sy   = CW'($urandom_range(COORD_MAX));
         span = ($urandom_range(9) == 0) ? 150 : 20;
         if (kind < 65) begin
            run_line(sx, sy, near_coord(int'(sx), span), near_coord(int'(sy), span),
                     ($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0);
         end else if (kind < 80) begin
            send_beat(CMD_START, sx, sy, near_coord(int'(sx), span),
                      near_coord(int'(sy), span));
            if (line_left != '0) step_line($urandom_range(int'(line_left) - 1));
         end else if (kind < 90) begin
            send_beat(CMD_START, sx, sy, CW'($urandom), CW'($urandom));
            step_line($urandom_range(60));
         end else begin
            send_beat(cmd_type'($urandom_range(1)), CW'($urandom), CW'($urandom),
                      CW'($urandom), CW'($urandom));
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_after_reset();
      test_directed_lines();
      test_color_settings();
      test_random_lines();
      idle_on = 1'b0;
      drain_pixels();
      repeat (4) @(posedge clock);
      if (mismatches == 0 && pending_pixels.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/lps_pkg.sv
rtl/core/lps_axis_setup.sv
rtl/core/lps_axis_advance.sv
rtl/core/line_pixel_stepper_top.sv
dv/tb_top.sv
